// ----- rtl/core/wsd_pkg.sv -----
`timescale 1ns / 1ps

package wsd_pkg;

  localparam logic [31:0] MAX_LEN_RESET = 32'd999999999;
  localparam logic [3:0]  OP_CONT       = 4'h0;
  localparam logic [3:0]  OP_TEXT       = 4'h1;
  localparam logic [3:0]  OP_BINARY     = 4'h2;
  localparam logic [3:0]  OP_CLOSE      = 4'h8;
  localparam logic [6:0]  LEN_EXT16     = 7'd126;
  localparam logic [6:0]  LEN_EXT64     = 7'd127;
  localparam logic [3:0]  EXT16_BYTES   = 4'd2;
  localparam logic [3:0]  EXT64_BYTES   = 4'd8;
  localparam logic [3:0]  MASK_BYTES    = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_NO_MASK,
    ERR_TOO_LARGE,
    ERR_BAD_FRAG
  } err_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] message_opcode;
    logic       frame_end;
    logic       message_end;
    err_t       error_code;
  } wsd_result_t;

  typedef struct packed {
    logic   halted;
    phase_t phase;
  } wsd_status_t;

endpackage

// ----- rtl/core/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps

// Client-to-server websocket deframer for one connection. It takes one stream
// byte per cycle with no gaps of its own: header bytes are absorbed, each
// payload byte comes out unmasked in the cycle after it is taken, along with the
// message opcode and frame/message end flags. The cycle is set by the 64-bit
// remaining-length decrement and the length limit compare in the parser. The
// input stalls only while a result sits in the output register and the far
// side stalls. A missing mask, an oversized length or a fragmented control
// frame gives one error beat and stops the block until reset; after a closing
// frame all bytes are dropped. The length limit is register 0 at address 0.

module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_byte,
  output logic [3:0]  out_message_opcode,
  output logic        out_frame_end,
  output logic        out_message_end,
  output logic [1:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        max_len_wr;
  logic [31:0] max_len_r;
  logic        in_acc;
  wsd_result_t res;
  wsd_status_t status;
  wsd_result_t out_r;

  assign pready     = 1'b1;
  assign max_len_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata     = paddr[2] ? 32'd0 : max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (max_len_wr) begin
      max_len_r <= pwdata;
    end
  end

  assign in_stall = out_r.valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .stream_byte (in_stream_byte),
    .max_len     (max_len_r),
    .res         (res),
    .status      (status)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (!out_r.valid || !out_stall) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_r.valid;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_has_byte       = out_r.has_byte;
  assign out_message_opcode = out_r.message_opcode;
  assign out_frame_end      = out_r.frame_end;
  assign out_message_end    = out_r.message_end;
  assign out_error_code     = out_r.error_code;

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.error_code != ERR_NONE) |=> status.halted)
    else $error("error beat did not halt the parser");

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    status.halted |-> !res.valid)
    else $error("halted parser produced a beat");

  a_msg_end_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_message_end) |-> out_frame_end)
    else $error("message end without frame end");

  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (status.phase == PH_CLOSED) |=> (status.phase == PH_CLOSED) && !res.valid)
    else $error("activity after close frame");

endmodule

// ----- rtl/core/wsd_parser.sv -----
`timescale 1ns / 1ps

module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  stream_byte,
  input  logic [31:0] max_len,
  output wsd_result_t res,
  output wsd_status_t status
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0] remaining_r, remaining_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [1:0]  mask_idx_r, mask_idx_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [3:0]  frag_r, frag_nxt;
  logic        halted_r, halted_nxt;

  logic [3:0]  frag_upd;
  logic [3:0]  eff_op;
  logic [3:0]  cnt_dec;
  logic [63:0] ext_len;
  logic [63:0] rem_dec;
  logic [7:0]  mask_byte;
  logic        close_end;

  always_comb begin
    cnt_dec   = (hdr_cnt_r != 4'd0) ? hdr_cnt_r - 4'd1 : 4'd0;
    ext_len   = {remaining_r[55:0], stream_byte};
    rem_dec   = (remaining_r != 64'd0) ? remaining_r - 64'd1 : 64'd0;
    mask_byte = mask_key_r[5'd24 - {mask_idx_r, 3'b000} +: 8];
    frag_upd  = (!fin_r && (opcode_r == OP_TEXT || opcode_r == OP_BINARY)) ? opcode_r : frag_r;
    eff_op    = (opcode_r == OP_CONT) ? frag_upd : opcode_r;
    close_end = fin_r && (eff_op == OP_CLOSE);
  end

  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    remaining_nxt = remaining_r;
    mask_key_nxt  = mask_key_r;
    mask_idx_nxt  = mask_idx_r;
    fin_nxt       = fin_r;
    opcode_nxt    = opcode_r;
    frag_nxt      = frag_r;
    halted_nxt    = halted_r;
    res           = '0;
    res.error_code = ERR_NONE;
    if (step && !halted_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt    = stream_byte[7];
          opcode_nxt = stream_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          remaining_nxt = 64'd0;
          if (!stream_byte[7]) begin
            halted_nxt         = 1'b1;
            res.valid          = 1'b1;
            res.message_opcode = opcode_r;
            res.error_code     = ERR_NO_MASK;
          end else if (stream_byte[6:0] == LEN_EXT16 || stream_byte[6:0] == LEN_EXT64) begin
            hdr_cnt_nxt = (stream_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_nxt   = PH_EXTLEN;
          end else begin
            remaining_nxt = {57'd0, stream_byte[6:0]};
            if ({25'd0, stream_byte[6:0]} > max_len) begin
              halted_nxt         = 1'b1;
              res.valid          = 1'b1;
              res.message_opcode = opcode_r;
              res.error_code     = ERR_TOO_LARGE;
            end else begin
              phase_nxt    = PH_MASK;
              hdr_cnt_nxt  = MASK_BYTES;
              mask_key_nxt = 32'd0;
            end
          end
        end
        PH_EXTLEN: begin
          remaining_nxt = ext_len;
          hdr_cnt_nxt   = cnt_dec;
          if (cnt_dec == 4'd0) begin
            if (ext_len > {32'd0, max_len}) begin
              halted_nxt         = 1'b1;
              res.valid          = 1'b1;
              res.message_opcode = opcode_r;
              res.error_code     = ERR_TOO_LARGE;
            end else begin
              phase_nxt    = PH_MASK;
              hdr_cnt_nxt  = MASK_BYTES;
              mask_key_nxt = 32'd0;
            end
          end
        end
        PH_MASK: begin
          mask_key_nxt = {mask_key_r[23:0], stream_byte};
          hdr_cnt_nxt  = cnt_dec;
          if (cnt_dec == 4'd0) begin
            if (!fin_r && opcode_r > OP_BINARY) begin
              halted_nxt         = 1'b1;
              res.valid          = 1'b1;
              res.message_opcode = opcode_r;
              res.error_code     = ERR_BAD_FRAG;
            end else begin
              frag_nxt     = frag_upd;
              mask_idx_nxt = 2'd0;
              if (remaining_r == 64'd0) begin
                res.valid          = 1'b1;
                res.message_opcode = eff_op;
                res.frame_end      = 1'b1;
                res.message_end    = fin_r;
                if (fin_r && opcode_r == OP_CONT) begin
                  frag_nxt = 4'd0;
                end
                phase_nxt = close_end ? PH_CLOSED : PH_HDR0;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          mask_idx_nxt       = mask_idx_r + 2'd1;
          remaining_nxt      = rem_dec;
          res.valid          = 1'b1;
          res.payload_byte   = stream_byte ^ mask_byte;
          res.has_byte       = 1'b1;
          res.message_opcode = eff_op;
          if (rem_dec == 64'd0) begin
            res.frame_end   = 1'b1;
            res.message_end = fin_r;
            if (fin_r && opcode_r == OP_CONT) begin
              frag_nxt = 4'd0;
            end
            phase_nxt = close_end ? PH_CLOSED : PH_HDR0;
          end
        end
        PH_CLOSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      hdr_cnt_r   <= 4'd0;
      remaining_r <= 64'd0;
      mask_key_r  <= 32'd0;
      mask_idx_r  <= 2'd0;
      fin_r       <= 1'b0;
      opcode_r    <= 4'd0;
      frag_r      <= 4'd0;
      halted_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      remaining_r <= remaining_nxt;
      mask_key_r  <= mask_key_nxt;
      mask_idx_r  <= mask_idx_nxt;
      fin_r       <= fin_nxt;
      opcode_r    <= opcode_nxt;
      frag_r      <= frag_nxt;
      halted_r    <= halted_nxt;
    end
  end

  assign status.halted = halted_r;
  assign status.phase  = phase_r;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb import wsd_pkg::*; ();

  localparam logic [2:0] MAX_LEN_ADDR = 3'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic [3:0] opcode;
    logic       fend;
    logic       mend;
    err_t       err;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_has_byte;
  logic [3:0]  out_message_opcode;
  logic        out_frame_end;
  logic        out_message_end;
  logic [1:0]  out_error_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  websocket_frame_deframer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stream_byte     (in_stream_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_has_byte       (out_has_byte),
    .out_message_opcode (out_message_opcode),
    .out_frame_end      (out_frame_end),
    .out_message_end    (out_message_end),
    .out_error_code     (out_error_code),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // deframer state as seen by the predictor
  logic [31:0] st_max_len = MAX_LEN_RESET;
  phase_t      st_phase = PH_HDR0;
  logic [3:0]  st_hdr_left = 4'd0;
  logic [63:0] st_left = 64'd0;
  logic [31:0] st_key = 32'd0;
  logic [1:0]  st_key_idx = 2'd0;
  logic        st_fin = 1'b0;
  logic [3:0]  st_op = 4'd0;
  logic [3:0]  st_frag = 4'd0;
  logic        st_halted = 1'b0;

  logic [7:0] wire_bytes[$];
  beat_t      unmasked_q[$];
  int         pushed = 0;
  int         bytes_taken = 0;
  int         mismatches = 0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 20) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic int pick_gap(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void raise_error(input err_t code);
    st_halted = 1'b1;
    unmasked_q.insert(unmasked_q.size(), '{8'h00, 1'b0, st_op, 1'b0, 1'b0, code});
  endfunction

  function automatic logic [3:0] eff_opcode();
    return (st_op == OP_CONT) ? st_frag : st_op;
  endfunction

  function automatic void close_frame(input logic [3:0] eff);
    if (st_fin && st_op == OP_CONT) st_frag = OP_CONT;
    st_phase = (st_fin && eff == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
  endfunction

  function automatic void length_ready();
    if (st_left > {32'd0, st_max_len}) begin
      raise_error(ERR_TOO_LARGE);
    end else begin
      st_phase = PH_MASK;
      st_hdr_left = MASK_BYTES;
      st_key = 32'd0;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [3:0]  eff;
    logic [31:0] shifted;
    logic [7:0]  data;
    logic        fe;
    if (st_halted) return;
    case (st_phase)
      PH_HDR0: begin
        st_fin = b[7];
        st_op = b[3:0];
        st_phase = PH_HDR1;
      end
      PH_HDR1: begin
        if (!b[7]) begin
          raise_error(ERR_NO_MASK);
        end else begin
          st_left = 64'd0;
          if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
            st_hdr_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            st_phase = PH_EXTLEN;
          end else begin
            st_left = {57'd0, b[6:0]};
            length_ready();
          end
        end
      end
      PH_EXTLEN: begin
        st_left = {st_left[55:0], b};
        if (st_hdr_left != 0) st_hdr_left--;
        if (st_hdr_left == 0) length_ready();
      end
      PH_MASK: begin
        st_key = {st_key[23:0], b};
        if (st_hdr_left != 0) st_hdr_left--;
        if (st_hdr_left == 0) begin
          if (!st_fin && st_op > OP_BINARY) begin
            raise_error(ERR_BAD_FRAG);
          end else begin
            if (!st_fin && (st_op == OP_TEXT || st_op == OP_BINARY)) st_frag = st_op;
            st_key_idx = 2'd0;
            if (st_left == 0) begin
              eff = eff_opcode();
              unmasked_q.insert(unmasked_q.size(),
                                '{8'h00, 1'b0, eff, 1'b1, st_fin, ERR_NONE});
              close_frame(eff);
            end else begin
              st_phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        shifted = st_key >> (24 - 8 * int'(st_key_idx));
        data = b ^ shifted[7:0];
        st_key_idx++;
        if (st_left != 0) st_left--;
        fe = (st_left == 0);
        eff = eff_opcode();
        unmasked_q.insert(unmasked_q.size(), '{data, 1'b1, eff, fe, fe & st_fin, ERR_NONE});
        if (fe) close_frame(eff);
      end
      default: ;
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_stall) begin
        // hold the beat
      end else begin
        if (in_valid) begin
          deframe_byte(in_stream_byte);
          bytes_taken <= bytes_taken + 1;
          tx_gap = pick_gap(tx_quiet);
        end
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (wire_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_stream_byte <= wire_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= 100) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  // receiver
  always @(posedge clk) begin : rx
    beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (unmasked_q.size() == 0) begin
          flag_mismatch("beat with nothing expected");
        end else begin
          want = unmasked_q.pop_front();
          if (out_payload_byte !== want.data)
            flag_mismatch($sformatf("payload_byte %0h want %0h", out_payload_byte, want.data));
          if (out_has_byte !== want.has)
            flag_mismatch($sformatf("has_byte %0b want %0b", out_has_byte, want.has));
          if (out_message_opcode !== want.opcode)
            flag_mismatch($sformatf("message_opcode %0h want %0h", out_message_opcode,
                                    want.opcode));
          if (out_frame_end !== want.fend)
            flag_mismatch($sformatf("frame_end %0b want %0b", out_frame_end, want.fend));
          if (out_message_end !== want.mend)
            flag_mismatch($sformatf("message_end %0b want %0b", out_message_end, want.mend));
          if (out_error_code !== want.err)
            flag_mismatch($sformatf("error_code %0d want %0d", out_error_code, want.err));
        end
        rx_gap = pick_gap(rx_quiet);
      end else if (rx_gap != 0) begin
        rx_gap--;
      end
      out_stall <= (rx_gap != 0) || (hold_left != 0);
    end
  end

  task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= MAX_LEN_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) st_max_len = wdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_max_len();
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    if (rd !== st_max_len)
      flag_mismatch($sformatf("max_payload_length read %0h want %0h", rd, st_max_len));
  endtask

  task automatic set_max_len(input logic [31:0] v);
    logic [31:0] rd;
    apb_access(1'b1, v, rd);
    check_max_len();
  endtask

  task automatic settle(input int extra);
    while (wire_bytes.size() != 0 || in_valid || unmasked_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic void send(input logic [7:0] b);
    wire_bytes.insert(wire_bytes.size(), b);
    pushed++;
  endfunction

  function automatic logic [3:0] data_op();
    return $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
  endfunction

  // control and reserved opcodes other than close
  function automatic logic [3:0] ctrl_op();
    logic [3:0] op;
    do op = 4'($urandom_range(3, 15)); while (op == OP_CLOSE);
    return op;
  endfunction

  function automatic int pick_len();
    int r;
    int len;
    r = $urandom_range(0, 19);
    if (r < 14) len = $urandom_range(0, 12);
    else if (r < 18) len = $urandom_range(13, 125);
    else len = $urandom_range(126, 300);
    if (len > st_max_len) len = st_max_len;
    return len;
  endfunction

  function automatic void push_header(input bit fin, input logic [3:0] opc,
                                      input logic [63:0] len, input int form);
    send({fin, 3'($urandom_range(0, 7)), opc});
    case (form)
      0: send({1'b1, len[6:0]});
      1: begin
        send({1'b1, LEN_EXT16});
        send(len[15:8]);
        send(len[7:0]);
      end
      default: begin
        send({1'b1, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send(len[8*i +: 8]);
      end
    endcase
    repeat (4) send(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_frame(input bit fin, input logic [3:0] opc, input int len);
    int form;
    if (len <= 125) form = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    else form = $urandom_range(1, 2);
    push_header(fin, opc, 64'(len), form);
    repeat (len) send(8'($urandom_range(0, 255)));
  endfunction

  function automatic void random_messages(input int nbytes);
    int stop;
    int kind;
    stop = pushed + nbytes;
    while (pushed < stop) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        push_frame(1'b1, data_op(), pick_len());
      end else if (kind < 7) begin
        push_frame(1'b0, data_op(), pick_len());
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 3) == 0) push_frame(1'b1, ctrl_op(), pick_len());
          push_frame(1'b0, OP_CONT, pick_len());
        end
        push_frame(1'b1, OP_CONT, pick_len());
      end else if (kind < 9) begin
        push_frame(1'b1, ctrl_op(), pick_len());
      end else begin
        // stray continuation or a data frame that breaks an open message
        push_frame(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? OP_CONT : data_op(),
                   pick_len());
      end
    end
  endfunction

  // one of the four ways the block stops for good, then bytes it must drop
  function automatic void push_terminal();
    case ($urandom_range(0, 3))
      0: begin
        send({1'b1, 3'($urandom_range(0, 7)), OP_TEXT});
        send({1'b0, 7'($urandom_range(0, 127))});
      end
      1: begin
        if ($urandom_range(0, 1))
          push_header(1'b1, data_op(), {32'd0, st_max_len} + 64'd1, $urandom_range(0, 2));
        else
          push_header(1'b1, OP_BINARY, {1'b1, 31'($urandom), 32'($urandom)}, 2);
      end
      2: push_header(1'b0, 4'($urandom_range(3, 15)), 64'(pick_len()), 0);
      default: push_frame(1'b1, OP_CLOSE, pick_len());
    endcase
    repeat (20) send(8'($urandom_range(0, 255)));
  endfunction

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_max_len();

    push_header(1'b1, OP_TEXT, 64'd0, 0);
    push_header(1'b0, OP_BINARY, 64'd1, 1);
    send(8'hFF);
    push_header(1'b1, OP_CONT, 64'd2, 2);
    send(8'h00);
    send(8'hFF);
    random_messages(200);
    settle(8);

    set_max_len(32'hFFFF_FFFF);
    random_messages(200);
    settle(8);

    set_max_len(32'd0);
    random_messages(60);
    settle(8);

    set_max_len(32'($urandom_range(1, 40)));
    push_frame(1'b1, OP_BINARY, st_max_len);
    random_messages(140);
    push_terminal();

    settle(20);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
